@@ design/ccfd_pkg.sv @@
`timescale 1ns / 1ps

package ccfd_pkg;

    // Longest frame in decoded bytes, CRC byte included.
    localparam int MAX_FRAME = 64;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = $clog2(MAX_FRAME + 1);
    localparam int NCP_W   = 9;
    localparam int IDX_W   = 6;
    localparam int FLEN_W  = 7;
    localparam int TDATA_W = 24;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_ABORT  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [IDX_W-1:0]   byte_index;
        logic [FLEN_W-1:0]  frame_length;
    } result_t;

    // Reflected CRC-8 update, one byte, least significant bit first.
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] crc;
        logic              fb;
        crc = crc_in;
        for (int i = 0; i < BYTE_W; i++) begin
            fb  = crc[0] ^ data[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

@@ design/ccfd_in_stage.sv @@
`timescale 1ns / 1ps

module ccfd_in_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ccfd_pkg::BYTE_W-1:0]  s_byte,
    input  logic                         advance,
    output logic                         byte_valid,
    output logic [ccfd_pkg::BYTE_W-1:0]  byte_out
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [ccfd_pkg::BYTE_W-1:0] byte_reg;

    // The stage refills in the same cycle that its byte moves on.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_out   = byte_reg;

endmodule

@@ design/ccfd_core.sv @@
`timescale 1ns / 1ps

module ccfd_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic [ccfd_pkg::BYTE_W-1:0]  rx_byte,
    output logic                         has_result,
    output ccfd_pkg::result_t            result
);

    logic [ccfd_pkg::NCP_W-1:0]  ncp_reg, ncp_next;
    logic [ccfd_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ccfd_pkg::BYTE_W-1:0] rcrc_reg, rcrc_next;
    logic [ccfd_pkg::BYTE_W-1:0] crc_reg, crc_next;
    logic [ccfd_pkg::NCP_W-1:0]  pos_plus1;
    logic [ccfd_pkg::BYTE_W-1:0] value;
    logic                        crc_ok;

    assign pos_plus1 = ccfd_pkg::NCP_W'(count_reg) + ccfd_pkg::NCP_W'(1);
    assign crc_ok    = (count_reg != '0) && (crc_reg == rcrc_reg);

    always_comb begin
        ncp_next   = ncp_reg;
        count_next = count_reg;
        rcrc_next  = rcrc_reg;
        crc_next   = crc_reg;
        has_result = 1'b0;
        result     = '0;
        value      = rx_byte;
        priority if (ncp_reg == '0) begin
            // First byte of a frame is the code byte; a zero here keeps waiting.
            ncp_next = ccfd_pkg::NCP_W'(rx_byte);
        end else if (rx_byte == '0) begin
            has_result          = 1'b1;
            result.kind         = crc_ok ? ccfd_pkg::KIND_ACCEPT : ccfd_pkg::KIND_REJECT;
            result.frame_length = ccfd_pkg::FLEN_W'(count_reg);
            ncp_next   = '0;
            count_next = '0;
            rcrc_next  = ccfd_pkg::CRC_INIT;
            crc_next   = ccfd_pkg::CRC_INIT;
        end else if (count_reg >= ccfd_pkg::CNT_W'(ccfd_pkg::MAX_FRAME)) begin
            has_result          = 1'b1;
            result.kind         = ccfd_pkg::KIND_ABORT;
            result.frame_length = ccfd_pkg::FLEN_W'(count_reg);
            ncp_next   = '0;
            count_next = '0;
            rcrc_next  = ccfd_pkg::CRC_INIT;
            crc_next   = ccfd_pkg::CRC_INIT;
        end else begin
            if (pos_plus1 == ncp_reg) begin
                // A code byte stands for a stuffed zero and points to the next one.
                value    = '0;
                ncp_next = ccfd_pkg::NCP_W'(rx_byte) + pos_plus1;
            end
            if (count_reg == '0) begin
                rcrc_next = value;
            end else begin
                crc_next = ccfd_pkg::crc8_byte(crc_reg, value);
            end
            count_next        = count_reg + ccfd_pkg::CNT_W'(1);
            has_result        = 1'b1;
            result.kind       = ccfd_pkg::KIND_DATA;
            result.data_byte  = value;
            result.byte_index = ccfd_pkg::IDX_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncp_reg   <= '0;
            count_reg <= '0;
            rcrc_reg  <= ccfd_pkg::CRC_INIT;
            crc_reg   <= ccfd_pkg::CRC_INIT;
        end else if (advance) begin
            ncp_reg   <= ncp_next;
            count_reg <= count_next;
            rcrc_reg  <= rcrc_next;
            crc_reg   <= crc_next;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ccfd_pkg::CNT_W'(ccfd_pkg::MAX_FRAME))
        else $error("decoded byte count exceeds the frame limit");

    a_awaiting_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (ncp_reg == '0) |-> (count_reg == '0 && crc_reg == ccfd_pkg::CRC_INIT))
        else $error("frame state not cleared while waiting for a code byte");

    a_verdict_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && has_result && result.kind != ccfd_pkg::KIND_DATA)
        |=> (ncp_reg == '0 && count_reg == '0))
        else $error("frame state not cleared after a verdict");

endmodule

@@ design/ccfd_out_stage.sv @@
`timescale 1ns / 1ps

module ccfd_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  ccfd_pkg::result_t  result_in,
    output logic               m_valid,
    input  logic               m_ready,
    output ccfd_pkg::result_t  result_out
);

    logic              valid_reg;
    logic              valid_next;
    ccfd_pkg::result_t result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = result_reg;

endmodule

@@ design/cobs_crc8_frame_decoder.sv @@
`timescale 1ns / 1ps

// COBS frame decoder with CRC-8 check for a byte stream from a serial link.
// The slave channel takes one raw received byte per transaction. The master
// channel gives at most one result per byte: a decoded byte with its index in
// the frame (index 0 is the sent CRC), or on the zero delimiter a verdict of
// accepted or rejected with the frame length, or an overflow abort when a
// frame grows past the frame limit. The code byte that opens a frame produces
// no result; later code bytes come out as decoded zero bytes.
// A byte taken into the input register has its result loaded into the output
// register on the master channel once that register is empty or being taken.
// Throughput: one byte per cycle unless the receiver stalls; the CRC update
// and the code position compare sit between the input and output registers.
// Frames are not buffered: decoded bytes leave as they arrive, and the
// consumer drops a frame whose verdict is a reject or an abort.
// Reset (aresetn low at a clock edge) empties both registers and returns the
// decoder to waiting for a code byte. When the receiver holds m_axis_tready
// low, the output register keeps its result, the input register keeps or takes
// one byte, and s_axis_tready then drops until the output moves.
module cobs_crc8_frame_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ccfd_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] data_byte, [13:8] byte_index, [20:14] frame_length, [23:21] zero
    output logic [ccfd_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                    m_axis_tuser   // [1:0] kind
);

    logic                        byte_valid;
    logic [ccfd_pkg::BYTE_W-1:0] byte_q;
    logic                        advance;
    logic                        has_result;
    ccfd_pkg::result_t           core_result;
    ccfd_pkg::result_t           out_result;

    assign advance = byte_valid && (!m_axis_tvalid || m_axis_tready);

    ccfd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_byte     (s_axis_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_out   (byte_q)
    );

    ccfd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .rx_byte    (byte_q),
        .has_result (has_result),
        .result     (core_result)
    );

    ccfd_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && has_result),
        .result_in  (core_result),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .result_out (out_result)
    );

    assign m_axis_tdata = {3'b000, out_result.frame_length,
                           out_result.byte_index, out_result.data_byte};
    assign m_axis_tuser = out_result.kind;

    a_data_no_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_result.kind == ccfd_pkg::KIND_DATA)
        |-> (out_result.frame_length == '0))
        else $error("decoded byte transaction carries a frame length");

    a_verdict_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_result.kind != ccfd_pkg::KIND_DATA)
        |-> (out_result.data_byte == '0 && out_result.byte_index == '0))
        else $error("verdict transaction carries byte data");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result transaction changed or dropped");

endmodule
